// ----- hdl/stok_pkg.sv -----
// Package for the source tokenizer: lexer modes, token kinds, error codes,
// byte constants, the result record type and the byte class functions.
// No dependencies.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int MAX_RES   = 4;
    localparam int QDEPTH    = 8;
    localparam int OUT_LINE_W = 24;
    localparam int OUT_COL_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam int DEF_LINE_BITS  = 24;
    localparam int DEF_COL_BITS   = 16;
    localparam int DEF_DEPTH_BITS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLUMN = 8'd1;

    typedef enum logic [2:0] {
        M_SKIP = 3'd0,
        M_SYM  = 3'd1,
        M_NUM  = 3'd2,
        M_STR  = 3'd3,
        M_CHAR = 3'd4,
        M_DIR  = 3'd5,
        M_OP   = 3'd6,
        M_HALT = 3'd7
    } lex_mode_t;

    localparam logic [4:0] K_EOF    = 5'd0;
    localparam logic [4:0] K_SYM    = 5'd1;
    localparam logic [4:0] K_NUM    = 5'd2;
    localparam logic [4:0] K_STR    = 5'd3;
    localparam logic [4:0] K_CHAR   = 5'd4;
    localparam logic [4:0] K_IF_DIR = 5'd5;
    localparam logic [4:0] K_EQEQ   = 5'd6;
    localparam logic [4:0] K_PLUS   = 5'd7;
    localparam logic [4:0] K_MINUS  = 5'd8;
    localparam logic [4:0] K_STAR   = 5'd9;
    localparam logic [4:0] K_PCT    = 5'd10;
    localparam logic [4:0] K_SLASH  = 5'd11;
    localparam logic [4:0] K_SEMI   = 5'd12;
    localparam logic [4:0] K_COLON  = 5'd13;
    localparam logic [4:0] K_ASSIGN = 5'd14;
    localparam logic [4:0] K_DOT    = 5'd15;
    localparam logic [4:0] K_COMMA  = 5'd16;
    localparam logic [4:0] K_LPAR   = 5'd17;
    localparam logic [4:0] K_RPAR   = 5'd18;
    localparam logic [4:0] K_LBRACE = 5'd19;
    localparam logic [4:0] K_RBRACE = 5'd20;
    localparam logic [4:0] K_LBRACK = 5'd21;
    localparam logic [4:0] K_RBRACK = 5'd22;
    localparam logic [4:0] K_ARROW  = 5'd23;
    localparam logic [4:0] K_PROC   = 5'd24;
    localparam logic [4:0] K_TYPE   = 5'd25;
    localparam logic [4:0] K_IF     = 5'd26;
    localparam logic [4:0] K_ELSE   = 5'd27;
    localparam logic [4:0] K_VAR    = 5'd28;
    localparam logic [4:0] K_RETURN = 5'd29;

    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_STRAY_END  = 3'd1;
    localparam logic [2:0] E_OPEN_CMT   = 3'd2;
    localparam logic [2:0] E_BAD_ESC    = 3'd3;
    localparam logic [2:0] E_ESC_AT_END = 3'd4;
    localparam logic [2:0] E_BAD_OP     = 3'd5;
    localparam logic [2:0] E_BAD_DIR    = 3'd6;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_LF    = 8'h0a;
    localparam logic [7:0] C_VT    = 8'h0b;
    localparam logic [7:0] C_CR    = 8'h0d;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_DQ    = 8'h22;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_SQ    = 8'h27;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_STAR  = 8'h2a;
    localparam logic [7:0] C_PLUS  = 8'h2b;
    localparam logic [7:0] C_COMMA = 8'h2c;
    localparam logic [7:0] C_MINUS = 8'h2d;
    localparam logic [7:0] C_DOT   = 8'h2e;
    localparam logic [7:0] C_SLASH = 8'h2f;
    localparam logic [7:0] C_D0    = 8'h30;
    localparam logic [7:0] C_D9    = 8'h39;
    localparam logic [7:0] C_COLON = 8'h3a;
    localparam logic [7:0] C_SEMI  = 8'h3b;
    localparam logic [7:0] C_EQ    = 8'h3d;
    localparam logic [7:0] C_GT    = 8'h3e;
    localparam logic [7:0] C_LBRK  = 8'h5b;
    localparam logic [7:0] C_BSL   = 8'h5c;
    localparam logic [7:0] C_RBRK  = 8'h5d;
    localparam logic [7:0] C_N     = 8'h6e;
    localparam logic [7:0] C_LBRC  = 8'h7b;
    localparam logic [7:0] C_RBRC  = 8'h7d;

    typedef struct packed {
        logic                  is_token;
        logic [7:0]            content;
        logic [4:0]            token_kind;
        logic [OUT_LINE_W-1:0] start_line;
        logic [OUT_COL_W-1:0]  start_col;
        logic [2:0]            error_code;
        logic                  last;
    } stok_res_t;

    function automatic logic space_char(input logic [7:0] c);
        return c == C_SP || c == C_LF || c == C_CR || c == C_VT || c == C_NUL;
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= C_D0 && c <= C_D9;
    endfunction

    function automatic logic [4:0] single_op(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            C_PLUS:  k = K_PLUS;
            C_MINUS: k = K_MINUS;
            C_STAR:  k = K_STAR;
            C_PCT:   k = K_PCT;
            C_SLASH: k = K_SLASH;
            C_SEMI:  k = K_SEMI;
            C_COLON: k = K_COLON;
            C_EQ:    k = K_ASSIGN;
            C_DOT:   k = K_DOT;
            C_COMMA: k = K_COMMA;
            C_LPAR:  k = K_LPAR;
            C_RPAR:  k = K_RPAR;
            C_LBRC:  k = K_LBRACE;
            C_RBRC:  k = K_RBRACE;
            C_LBRK:  k = K_LBRACK;
            C_RBRK:  k = K_RBRACK;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic sym_char(input logic [7:0] c);
        return c != C_SLASH && !space_char(c) && single_op(c) == K_EOF;
    endfunction

    // Word bytes are packed first byte lowest.
    function automatic logic [4:0] sym_kind(input logic [47:0] w, input logic [2:0] n);
        logic [4:0] k;
        k = K_SYM;
        if (n == 3'd4 && w[31:0] == 32'h636f7270) k = K_PROC;
        else if (n == 3'd4 && w[31:0] == 32'h65707974) k = K_TYPE;
        else if (n == 3'd2 && w[15:0] == 16'h6669) k = K_IF;
        else if (n == 3'd4 && w[31:0] == 32'h65736c65) k = K_ELSE;
        else if (n == 3'd3 && w[23:0] == 24'h726176) k = K_VAR;
        else if (n == 3'd6 && w[47:0] == 48'h6e7275746572) k = K_RETURN;
        return k;
    endfunction

    function automatic logic dir_is_if(input logic [47:0] w, input logic [2:0] n);
        return n == 3'd3 && w[23:0] == 24'h666923;
    endfunction

endpackage

// ----- hdl/stok_if.sv -----
// Channel interfaces of the source tokenizer: source bytes, results and
// configuration writes. No dependencies.
`timescale 1ns / 1ps

interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_mark;
    modport source (output valid, output ch, output end_mark, input ready);
    modport sink (input valid, input ch, input end_mark, output ready);
endinterface

interface stok_out_if;
    logic        valid;
    logic        ready;
    logic        is_token;
    logic [7:0]  content;
    logic [4:0]  token_kind;
    logic [23:0] start_line;
    logic [15:0] start_col;
    logic [2:0]  error_code;
    logic        last;
    modport source (output valid, output is_token, output content, output token_kind,
                    output start_line, output start_col, output error_code,
                    output last, input ready);
    modport sink (input valid, input is_token, input content, input token_kind,
                  input start_line, input start_col, input error_code,
                  input last, output ready);
endinterface

interface stok_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/stok_queue.sv -----
// Result queue: takes up to MAX_RES records per cycle, hands out one.
// Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_queue
    import stok_pkg::*;
#(
    parameter int DEPTH = QDEPTH
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [2:0]                 push_cnt,
    input  stok_res_t                  push_data [MAX_RES],
    input  logic                       pop,
    output stok_res_t                  head,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    stok_res_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_pop;

    assign do_pop = pop && cnt_reg != '0;
    assign head   = mem_reg[rd_reg];
    assign count  = cnt_reg;
    assign cnt_next = cnt_reg + CW'(push_cnt) - CW'(do_pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (3'(k) < push_cnt)
            begin
                mem_reg[wr_reg + PW'(k)] <= push_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + PW'(push_cnt);
            rd_reg  <= rd_reg + PW'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(DEPTH))
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 && push_cnt == 3'd0) |=> cnt_reg == '0)
        else $error("queue count changed with no transfer");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_next <= CW'(DEPTH))
        else $error("push beyond queue space");
endmodule

// ----- hdl/source_tokenizer.sv -----
// Source tokenizer top level: byte lexer with one-byte lookahead and a result
// queue. Depends on stok_pkg, stok_if and stok_queue.
`timescale 1ns / 1ps

// Usage
//   src : source bytes (ch, end_mark). One transfer per cycle is taken while
//         the result queue has room for a full burst of four results.
//   tok : result records, one per transfer, in model order. A content byte
//         has is_token 0; token, eof and error records have is_token 1.
//   cfg : writes first_line (index 0) and first_column (index 1); other
//         indexes are dropped. Always ready; write only while idle.
// Timing
//   A byte is decided when the next byte (or the end) arrives. Each accepted
//   transfer is lexed in the same cycle and its zero to four results land in
//   the queue at that edge; tok shows them in order from the queue head.
//   Throughput is one source byte per cycle, set by the queue drain of one
//   result per cycle when bytes produce more than one result each.
// Reset
//   rst_n clears all lexer state but the word buffer, and empties the queue;
//   positions load from the config registers on the first byte of each source.
// Stall
//   When tok is held off, results wait in the queue; src drops ready once
//   fewer than four entries remain free.
module source_tokenizer
    import stok_pkg::*;
#(
    parameter int LINE_BITS  = DEF_LINE_BITS,
    parameter int COL_BITS   = DEF_COL_BITS,
    parameter int DEPTH_BITS = DEF_DEPTH_BITS
)(
    input  logic        clk,
    input  logic        rst_n,
    stok_in_if.sink     src,
    stok_out_if.source  tok,
    stok_cfg_if.sink    cfg
);
    localparam int CW = $clog2(QDEPTH+1);
    localparam logic [LINE_BITS-1:0]  LINE_TOP  = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]   COL_TOP   = {COL_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = {DEPTH_BITS{1'b1}};

    // configuration registers
    logic [OUT_LINE_W-1:0] first_line_reg;
    logic [OUT_COL_W-1:0]  first_col_reg;

    // lexer state
    lex_mode_t             mode_reg, mode_next;
    logic [7:0]            held_reg, held_next;
    logic                  hv_reg, hv_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  ilc_reg, ilc_next;
    logic                  esc_reg, esc_next;
    logic                  swal_reg, swal_next;
    logic                  fresh_reg, fresh_next;
    logic [7:0]            opf_reg, opf_next;
    logic [47:0]           wb_reg, wb_next;
    logic [2:0]            wl_reg, wl_next;
    logic [LINE_BITS-1:0]  cl_reg, cl_next, tl_reg, tl_next;
    logic [COL_BITS-1:0]   cc_reg, cc_next, tc_reg, tc_next;

    stok_res_t  res [MAX_RES];
    logic [2:0] rc;
    logic [2:0] push_cnt;
    logic       in_fire;
    logic [CW-1:0] q_count;
    stok_res_t  q_head;

    logic [LINE_BITS-1:0] load_line;
    logic [COL_BITS-1:0]  load_col;

    function automatic logic [OUT_LINE_W-1:0] fit_line(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+OUT_LINE_W-1:0] w;
        w = (LINE_BITS+OUT_LINE_W)'(v);
        return w[OUT_LINE_W-1:0];
    endfunction

    function automatic logic [OUT_COL_W-1:0] fit_col(input logic [COL_BITS-1:0] v);
        logic [COL_BITS+OUT_COL_W-1:0] w;
        w = (COL_BITS+OUT_COL_W)'(v);
        return w[OUT_COL_W-1:0];
    endfunction

    function automatic stok_res_t mk(input logic tk, input logic [7:0] ct,
                                     input logic [4:0] kd, input logic [LINE_BITS-1:0] ln,
                                     input logic [COL_BITS-1:0] cl, input logic [2:0] er,
                                     input logic lt);
        stok_res_t r;
        r.is_token   = tk;
        r.content    = ct;
        r.token_kind = kd;
        r.start_line = fit_line(ln);
        r.start_col  = fit_col(cl);
        r.error_code = er;
        r.last       = lt;
        return r;
    endfunction

    // saturate the configured start position into the counter widths
    always_comb
    begin
        logic [LINE_BITS+OUT_LINE_W-1:0] wl_v, tl_v;
        logic [COL_BITS+OUT_COL_W-1:0]   wc_v, tc_v;
        wl_v = (LINE_BITS+OUT_LINE_W)'(first_line_reg);
        tl_v = (LINE_BITS+OUT_LINE_W)'(LINE_TOP);
        wc_v = (COL_BITS+OUT_COL_W)'(first_col_reg);
        tc_v = (COL_BITS+OUT_COL_W)'(COL_TOP);
        load_line = (wl_v > tl_v) ? LINE_TOP : wl_v[LINE_BITS-1:0];
        load_col  = (wc_v > tc_v) ? COL_TOP : wc_v[COL_BITS-1:0];
    end

    assign src.ready = q_count <= CW'(QDEPTH - MAX_RES);
    assign in_fire   = src.valid && src.ready;
    assign cfg.ready = 1'b1;

    // next-state logic: one whole model step per accepted byte
    always_comb
    begin
        logic [7:0] c, n;
        logic       ends, done, halted;
        lex_mode_t  m;
        logic [DEPTH_BITS-1:0] dp;
        logic       ilc, esc, swal, fr, hv;
        logic [7:0] opf, hb;
        logic [47:0] wb;
        logic [2:0] wl;
        logic [LINE_BITS-1:0] cl, tl;
        logic [COL_BITS-1:0]  cc, tc;
        logic [7:0] d;
        logic       rearm;

        m = mode_reg; dp = depth_reg; ilc = ilc_reg; esc = esc_reg; swal = swal_reg;
        fr = fresh_reg; hv = hv_reg; opf = opf_reg; hb = held_reg; wb = wb_reg;
        wl = wl_reg; cl = cl_reg; cc = cc_reg; tl = tl_reg; tc = tc_reg;
        rc = 3'd0;
        rearm = 1'b0;
        d = C_NUL;
        for (int k = 0; k < MAX_RES; k++)
        begin
            res[k] = mk(1'b0, C_NUL, K_EOF, '0, '0, E_NONE, 1'b0);
        end
        ends = src.end_mark || src.ch == C_NUL;
        n = ends ? C_NUL : src.ch;
        c = hb;
        halted = 1'b0;
        done = 1'b0;

        if (in_fire)
        begin
            if (m == M_HALT)
            begin
                halted = 1'b1;
                rearm = src.end_mark;
            end
            else
            begin
                if (fr)
                begin
                    cl = load_line; cc = load_col; fr = 1'b0;
                end
                if (hv)
                begin
                    hv = 1'b0;
                    done = 1'b0;
                    // close the current token, pick the next mode, take the byte
                    for (int it = 0; it < 3; it++)
                    begin
                        if (!done)
                        begin
                            case (m)
                                M_SKIP:
                                begin
                                    done = 1'b1;
                                    if (swal) swal = 1'b0;
                                    else if (c == C_SLASH && n == C_STAR)
                                    begin
                                        tl = cl; tc = cc;
                                        if (dp != DEPTH_TOP) dp = dp + 1'b1;
                                        swal = 1'b1;
                                    end
                                    else if (c == C_STAR && n == C_SLASH)
                                    begin
                                        if (dp == '0)
                                        begin
                                            res[rc[1:0]] = mk(1'b1, C_NUL, K_EOF, cl, cc,
                                                              E_STRAY_END, 1'b1);
                                            rc = rc + 3'd1;
                                            m = M_HALT;
                                        end
                                        else
                                        begin
                                            dp = dp - 1'b1;
                                            swal = 1'b1;
                                        end
                                    end
                                    else if (ilc)
                                    begin
                                        if (c == C_LF || c == C_CR) ilc = 1'b0;
                                    end
                                    else if (c == C_SLASH && n == C_SLASH) ilc = 1'b1;
                                    else if (dp != '0 || space_char(c)) ;
                                    else
                                    begin
                                        tl = cl; tc = cc; wl = 3'd0;
                                        if (c == C_SQ) m = M_CHAR;
                                        else if (c == C_DQ) m = M_STR;
                                        else if (c == C_HASH)
                                        begin
                                            m = M_DIR;
                                            wb[{wl, 3'b000} +: 8] = c;
                                            wl = 3'd1;
                                        end
                                        else
                                        begin
                                            done = 1'b0;
                                            if (digit_char(c) || (c == C_DOT && digit_char(n)))
                                                m = M_NUM;
                                            else if (single_op(c) != K_EOF) m = M_OP;
                                            else m = M_SYM;
                                        end
                                    end
                                end
                                M_SYM, M_NUM:
                                begin
                                    if (sym_char(c) || (m == M_NUM && c == C_DOT))
                                    begin
                                        if (wl < 3'd6) wb[{wl, 3'b000} +: 8] = c;
                                        if (wl < 3'd7) wl = wl + 3'd1;
                                        res[rc[1:0]] = mk(1'b0, c, K_EOF, '0, '0, E_NONE, 1'b0);
                                        rc = rc + 3'd1;
                                        done = 1'b1;
                                    end
                                    else
                                    begin
                                        res[rc[1:0]] = mk(1'b1, C_NUL,
                                            (m == M_NUM) ? K_NUM : sym_kind(wb, wl),
                                            tl, tc, E_NONE, 1'b0);
                                        rc = rc + 3'd1;
                                        m = M_SKIP;
                                    end
                                end
                                M_DIR:
                                begin
                                    if (sym_char(c))
                                    begin
                                        if (wl < 3'd6) wb[{wl, 3'b000} +: 8] = c;
                                        if (wl < 3'd7) wl = wl + 3'd1;
                                        done = 1'b1;
                                    end
                                    else if (dir_is_if(wb, wl))
                                    begin
                                        res[rc[1:0]] = mk(1'b1, C_NUL, K_IF_DIR, tl, tc,
                                                          E_NONE, 1'b0);
                                        rc = rc + 3'd1;
                                        m = M_SKIP;
                                    end
                                    else
                                    begin
                                        res[rc[1:0]] = mk(1'b1, C_NUL, K_EOF, tl, tc,
                                                          E_BAD_DIR, 1'b1);
                                        rc = rc + 3'd1;
                                        m = M_HALT;
                                        done = 1'b1;
                                    end
                                end
                                M_OP:
                                begin
                                    if (wl == 3'd0)
                                    begin
                                        opf = c; wl = 3'd1; done = 1'b1;
                                    end
                                    else if (wl == 3'd1 && ((opf == C_EQ && c == C_EQ) ||
                                                            (opf == C_MINUS && c == C_GT)))
                                    begin
                                        wl = 3'd2; done = 1'b1;
                                    end
                                    else
                                    begin
                                        res[rc[1:0]] = mk(1'b1, C_NUL,
                                            (wl == 3'd2) ? ((opf == C_EQ) ? K_EQEQ : K_ARROW)
                                                         : single_op(opf),
                                            tl, tc, E_NONE, 1'b0);
                                        rc = rc + 3'd1;
                                        m = M_SKIP;
                                    end
                                end
                                M_STR, M_CHAR:
                                begin
                                    done = 1'b1;
                                    if (esc)
                                    begin
                                        if (c == C_SQ || c == C_DQ) d = c;
                                        else if (c == C_N) d = C_LF;
                                        else d = C_NUL;
                                        if (d == C_NUL)
                                        begin
                                            res[rc[1:0]] = mk(1'b1, C_NUL, K_EOF, tl, tc,
                                                              E_BAD_ESC, 1'b1);
                                            rc = rc + 3'd1;
                                            m = M_HALT;
                                        end
                                        else
                                        begin
                                            esc = 1'b0;
                                            res[rc[1:0]] = mk(1'b0, d, K_EOF, '0, '0,
                                                              E_NONE, 1'b0);
                                            rc = rc + 3'd1;
                                        end
                                    end
                                    else if (c == C_BSL) esc = 1'b1;
                                    else if (c == ((m == M_STR) ? C_DQ : C_SQ))
                                    begin
                                        res[rc[1:0]] = mk(1'b1, C_NUL,
                                            (m == M_STR) ? K_STR : K_CHAR,
                                            tl, tc, E_NONE, 1'b0);
                                        rc = rc + 3'd1;
                                        m = M_SKIP;
                                    end
                                    else
                                    begin
                                        res[rc[1:0]] = mk(1'b0, c, K_EOF, '0, '0, E_NONE, 1'b0);
                                        rc = rc + 3'd1;
                                    end
                                end
                                default: done = 1'b1;
                            endcase
                        end
                    end
                    // advance the position past the held byte unless lexing stopped
                    if (m != M_HALT)
                    begin
                        if (c == C_LF)
                        begin
                            if (cl != LINE_TOP) cl = cl + 1'b1;
                            cc = '0;
                        end
                        else if (cc != COL_TOP) cc = cc + 1'b1;
                    end
                    else
                    begin
                        halted = 1'b1;
                        rearm = src.end_mark;
                    end
                end
                if (!halted)
                begin
                    if (ends)
                    begin
                        done = 1'b0;
                        if (m == M_STR || m == M_CHAR)
                        begin
                            if (esc)
                            begin
                                res[rc[1:0]] = mk(1'b1, C_NUL, K_EOF, tl, tc,
                                                  E_ESC_AT_END, 1'b1);
                                rc = rc + 3'd1;
                                done = 1'b1;
                            end
                        end
                        else
                        begin
                            case (m)
                                M_SYM, M_NUM:
                                begin
                                    res[rc[1:0]] = mk(1'b1, C_NUL,
                                        (m == M_NUM) ? K_NUM : sym_kind(wb, wl),
                                        tl, tc, E_NONE, 1'b0);
                                    rc = rc + 3'd1;
                                end
                                M_OP:
                                begin
                                    res[rc[1:0]] = mk(1'b1, C_NUL,
                                        (wl == 3'd2) ? ((opf == C_EQ) ? K_EQEQ : K_ARROW)
                                                     : single_op(opf),
                                        tl, tc, E_NONE, 1'b0);
                                    rc = rc + 3'd1;
                                end
                                M_DIR:
                                begin
                                    if (dir_is_if(wb, wl))
                                    begin
                                        res[rc[1:0]] = mk(1'b1, C_NUL, K_IF_DIR, tl, tc,
                                                          E_NONE, 1'b0);
                                        rc = rc + 3'd1;
                                    end
                                    else
                                    begin
                                        res[rc[1:0]] = mk(1'b1, C_NUL, K_EOF, tl, tc,
                                                          E_BAD_DIR, 1'b1);
                                        rc = rc + 3'd1;
                                        done = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                            if (!done && dp != '0)
                            begin
                                res[rc[1:0]] = mk(1'b1, C_NUL, K_EOF, tl, tc,
                                                  E_OPEN_CMT, 1'b1);
                                rc = rc + 3'd1;
                                done = 1'b1;
                            end
                        end
                        if (!done)
                        begin
                            res[rc[1:0]] = mk(1'b1, C_NUL, K_EOF, cl, cc, E_NONE, 1'b1);
                            rc = rc + 3'd1;
                        end
                        m = M_HALT;
                        rearm = src.end_mark;
                    end
                    else
                    begin
                        hb = src.ch;
                        hv = 1'b1;
                    end
                end
            end
        end

        if (rearm)
        begin
            m = M_SKIP; hb = C_NUL; hv = 1'b0; dp = '0; ilc = 1'b0; esc = 1'b0;
            swal = 1'b0; opf = C_NUL; wl = 3'd0; tl = '0; tc = '0; fr = 1'b1;
            cl = load_line; cc = load_col;
        end

        mode_next = m; held_next = hb; hv_next = hv; depth_next = dp; ilc_next = ilc;
        esc_next = esc; swal_next = swal; fresh_next = fr; opf_next = opf; wb_next = wb;
        wl_next = wl; cl_next = cl; cc_next = cc; tl_next = tl; tc_next = tc;
    end

    // output logic: queue push count and result port
    always_comb
    begin
        push_cnt       = in_fire ? rc : 3'd0;
        tok.valid      = q_count != '0;
        tok.is_token   = q_head.is_token;
        tok.content    = q_head.content;
        tok.token_kind = q_head.token_kind;
        tok.start_line = q_head.start_line;
        tok.start_col  = q_head.start_col;
        tok.error_code = q_head.error_code;
        tok.last       = q_head.last;
    end

    stok_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (res),
        .pop       (tok.ready),
        .head      (q_head),
        .count     (q_count)
    );

    // word buffer holds no reset; only bytes below the length are read
    always_ff @(posedge clk)
    begin
        wb_reg <= wb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg <= OUT_LINE_W'(1);
            first_col_reg  <= '0;
            mode_reg  <= M_SKIP;
            held_reg  <= C_NUL;
            hv_reg    <= 1'b0;
            depth_reg <= '0;
            ilc_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            swal_reg  <= 1'b0;
            fresh_reg <= 1'b1;
            opf_reg   <= C_NUL;
            wl_reg    <= 3'd0;
            cl_reg    <= '0;
            cc_reg    <= '0;
            tl_reg    <= '0;
            tc_reg    <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FIRST_LINE) first_line_reg <= cfg.data;
                else if (cfg.index == REG_FIRST_COLUMN)
                    first_col_reg <= cfg.data[OUT_COL_W-1:0];
            end
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            hv_reg    <= hv_next;
            depth_reg <= depth_next;
            ilc_reg   <= ilc_next;
            esc_reg   <= esc_next;
            swal_reg  <= swal_next;
            fresh_reg <= fresh_next;
            opf_reg   <= opf_next;
            wl_reg    <= wl_next;
            cl_reg    <= cl_next;
            cc_reg    <= cc_next;
            tl_reg    <= tl_next;
            tc_reg    <= tc_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode_reg == M_HALT) |-> push_cnt == 3'd0)
        else $error("result produced while halted");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fresh_reg && hv_reg))
        else $error("held byte before position load");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && push_cnt != 3'd0 && res[push_cnt[1:0] - 2'd1].last) |=>
        (mode_reg == M_HALT || fresh_reg))
        else $error("stream end without halt");
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(mode_reg))
        else $error("lexer mode moved without a transfer");
endmodule
